// ===== hdl/dlsq_pkg.sv =====
// Package with types and constants of the delta list sleep queue.
package dlsq_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned DelayBitsDefault  = 32;

  localparam logic [2:0] CmdPut    = 3'd0;
  localparam logic [2:0] CmdTick   = 3'd1;
  localparam logic [2:0] CmdPop    = 3'd2;
  localparam logic [2:0] CmdCancel = 3'd3;
  localparam logic [2:0] CmdClear  = 3'd4;

  localparam logic [1:0] StOk    = 2'd0;
  localparam logic [1:0] StFull  = 2'd1;
  localparam logic [1:0] StEmpty = 2'd2;
  localparam logic [1:0] StNull  = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  thread_id;
    logic [31:0] delay;
    logic [7:0]  awakener_id;
  } req_t;

  typedef struct packed {
    logic [7:0] thread_out;
    logic [1:0] status;
    logic       head_due;
    logic [4:0] removed_count;
    logic       last;
  } rsp_t;

endpackage

// ===== hdl/delta_list_sleep_queue_unit.sv =====
// Operation: put and cancel walk the table one entry at a time; tick lowers the delay of
// the head entry, stopping at zero; pop removes the head and moves later entries up.
// Throughput: one request at a time; a new request is taken only once the block is idle
// and the previous result has been accepted. Clear emits one result per entry and waits
// for each result to be accepted before it emits the next.
// Reset is asynchronous and active low; it empties the queue, table contents
// are undefined until written.
module delta_list_sleep_queue_unit
  import dlsq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDefault,
  parameter int unsigned DELAY_BITS  = DelayBitsDefault
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic req_valid_i,
  output logic req_ready_o,
  input  req_t req_i,
  output logic rsp_valid_o,
  input  logic rsp_ready_i,
  output rsp_t rsp_o
);
  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = 16 + DELAY_BITS;

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SRd    = 4'd1;
  localparam logic [3:0] SWait  = 4'd2;
  localparam logic [3:0] SPutCk = 4'd3;
  localparam logic [3:0] SShRd  = 4'd4;
  localparam logic [3:0] SShWt  = 4'd5;
  localparam logic [3:0] SShWr  = 4'd6;
  localparam logic [3:0] SIns   = 4'd7;
  localparam logic [3:0] SFix   = 4'd8;
  localparam logic [3:0] SCanCk = 4'd9;
  localparam logic [3:0] SHead  = 4'd10;
  localparam logic [3:0] SHeadW = 4'd11;
  localparam logic [3:0] SOut   = 4'd12;
  localparam logic [3:0] SClr   = 4'd13;
  localparam logic [3:0] SClrW  = 4'd14;

  logic [3:0]            state_q, state_d;
  logic [CW-1:0]         cnt_q, cnt_d;
  logic [AW-1:0]         pos_q, pos_d;
  logic [AW-1:0]         sh_q, sh_d;
  logic [DELAY_BITS-1:0] rem_q, rem_d;
  logic [DELAY_BITS-1:0] carry_q, carry_d;
  logic                  carry_v_q, carry_v_d;
  logic [CW-1:0]         rmv_q, rmv_d;
  logic [CW-1:0]         wr_q, wr_d;
  req_t                  req_q, req_d;
  rsp_t                  rsp_q, rsp_d;
  logic                  rsp_v_q, rsp_v_d;
  logic [2:0]            cmd;

  logic                  we;
  logic [AW-1:0]         addr;
  logic [EW-1:0]         wdata, rdata;
  logic [7:0]            r_thr, r_awk;
  logic [DELAY_BITS-1:0] r_dl;
  logic [DELAY_BITS-1:0] diff;
  logic [DELAY_BITS-1:0] in_delay;

  dlsq_ram #(.Width(EW), .Depth(QUEUE_DEPTH)) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .addr_i (addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  assign r_thr = rdata[EW-1 -: 8];
  assign r_awk = rdata[DELAY_BITS +: 8];
  assign r_dl  = rdata[DELAY_BITS-1:0];
  assign cmd   = req_q.command;
  assign diff  = r_dl - rem_q;

  if (DELAY_BITS >= 32) begin : g_wide
    assign in_delay = DELAY_BITS'(req_i.delay);
  end else begin : g_narrow
    assign in_delay = req_i.delay[DELAY_BITS-1:0];
  end

  assign req_ready_o = (state_q == SIdle) && !rsp_v_q;
  assign rsp_valid_o = rsp_v_q;
  assign rsp_o       = rsp_q;

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    pos_d     = pos_q;
    sh_d      = sh_q;
    rem_d     = rem_q;
    carry_d   = carry_q;
    carry_v_d = carry_v_q;
    rmv_d     = rmv_q;
    wr_d      = wr_q;
    req_d     = req_q;
    rsp_d     = rsp_q;
    rsp_v_d   = rsp_v_q;
    we        = 1'b0;
    addr      = pos_q;
    wdata     = rdata;
    if (rsp_v_q && rsp_ready_i) begin
      rsp_v_d = 1'b0;
    end
    unique case (state_q)
      SIdle: begin
        if (req_valid_i && req_ready_o) begin
          req_d     = req_i;
          pos_d     = '0;
          rem_d     = in_delay;
          rmv_d     = '0;
          wr_d      = '0;
          carry_v_d = 1'b0;
          rsp_d     = '0;
          rsp_d.last = 1'b1;
          if (req_i.command == CmdPut) begin
            if (req_i.thread_id == 8'd0) begin
              rsp_d.status = StNull;
              state_d      = SHead;
            end else if (cnt_q == CW'(QUEUE_DEPTH)) begin
              rsp_d.status = StFull;
              state_d      = SHead;
            end else begin
              state_d = (cnt_q == '0) ? SIns : SRd;
            end
          end else if (req_i.command == CmdTick || req_i.command == CmdPop) begin
            if (cnt_q == '0) begin
              rsp_d.status = StEmpty;
              state_d      = SOut;
            end else begin
              state_d = SRd;
            end
          end else if (req_i.command == CmdCancel) begin
            state_d = (cnt_q == '0) ? SOut : SRd;
          end else if (req_i.command == CmdClear) begin
            if (cnt_q == '0) begin
              rsp_d.status = StEmpty;
              state_d      = SOut;
            end else begin
              state_d = SClr;
            end
          end else begin
            state_d = SHead;
          end
        end
      end
      SRd: begin
        state_d = SWait;
      end
      SWait: begin
        state_d = SPutCk;
        if (cmd == CmdTick) begin
          we    = 1'b1;
          wdata = {r_thr, r_awk, (r_dl == '0) ? r_dl : r_dl - 1'b1};
          state_d = SHead;
        end else if (cmd == CmdPop) begin
          rsp_d.thread_out = r_thr;
          sh_d    = '0;
          state_d = (cnt_q > CW'(1)) ? SShRd : SHead;
          cnt_d   = cnt_q - 1'b1;
        end else if (cmd == CmdCancel) begin
          state_d = SCanCk;
        end
      end
      SPutCk: begin
        if (r_dl <= rem_q) begin
          rem_d = rem_q - r_dl;
          if (CW'(pos_q) + 1'b1 == cnt_q) begin
            pos_d   = pos_q + 1'b1;
            state_d = SIns;
          end else begin
            pos_d   = pos_q + 1'b1;
            state_d = SRd;
          end
        end else begin
          carry_d = diff;
          sh_d    = AW'(cnt_q - 1'b1);
          state_d = SShRd;
        end
      end
      SShRd: begin
        if (cmd == CmdPut) begin
          addr = sh_q;
        end else begin
          addr = sh_q + 1'b1;
        end
        state_d = SShWt;
      end
      SShWt: begin
        if (cmd == CmdPut) begin
          addr = sh_q;
        end else begin
          addr = sh_q + 1'b1;
        end
        state_d = SShWr;
      end
      SShWr: begin
        we = 1'b1;
        if (cmd == CmdPut) begin
          addr = sh_q + 1'b1;
          if (sh_q == pos_q) begin
            wdata   = {r_thr, r_awk, carry_q};
            state_d = SIns;
          end else begin
            sh_d    = sh_q - 1'b1;
            state_d = SShRd;
          end
        end else begin
          addr = sh_q;
          if (CW'(sh_q) + 2'd2 >= cnt_q + 1'b1) begin
            state_d = SHead;
          end else begin
            sh_d    = sh_q + 1'b1;
            state_d = SShRd;
          end
        end
      end
      SIns: begin
        we      = 1'b1;
        wdata   = {req_q.thread_id, req_q.awakener_id, rem_q};
        cnt_d   = cnt_q + 1'b1;
        state_d = SHead;
      end
      SCanCk: begin
        if (r_awk == req_q.awakener_id) begin
          rmv_d = rmv_q + 1'b1;
          if (carry_v_q) begin
            carry_d = carry_q + r_dl;
          end else begin
            carry_d = r_dl;
          end
          carry_v_d = 1'b1;
        end else begin
          we    = 1'b1;
          addr  = AW'(wr_q);
          wdata = {r_thr, r_awk, carry_v_q ? r_dl + carry_q : r_dl};
          carry_v_d = 1'b0;
          wr_d  = wr_q + 1'b1;
        end
        if (CW'(pos_q) + 1'b1 == cnt_q) begin
          cnt_d   = (r_awk == req_q.awakener_id) ? wr_q : wr_q + 1'b1;
          rsp_d.removed_count = 5'(rmv_d);
          state_d = SHead;
        end else begin
          pos_d   = pos_q + 1'b1;
          state_d = SRd;
        end
      end
      SHead: begin
        addr    = '0;
        state_d = SHeadW;
      end
      SHeadW: begin
        addr           = '0;
        rsp_d.head_due = (cnt_q != '0) && (r_dl == '0);
        state_d        = SOut;
      end
      SOut: begin
        if (!rsp_v_q) begin
          rsp_v_d = 1'b1;
          state_d = SIdle;
        end
      end
      SClr: begin
        if (!rsp_v_q || rsp_ready_i) begin
          state_d = SClrW;
        end
      end
      SClrW: begin
        if (!rsp_v_d) begin
          rsp_d   = '0;
          rsp_d.thread_out = r_thr;
          rsp_d.last = (CW'(pos_q) + 1'b1 == cnt_q);
          rsp_v_d = 1'b1;
          if (CW'(pos_q) + 1'b1 == cnt_q) begin
            cnt_d   = '0;
            state_d = SIdle;
          end else begin
            pos_d   = pos_q + 1'b1;
            state_d = SClr;
          end
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      cnt_q   <= '0;
      rsp_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      rsp_v_q <= rsp_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q     <= pos_d;
    sh_q      <= sh_d;
    rem_q     <= rem_d;
    carry_q   <= carry_d;
    carry_v_q <= carry_v_d;
    rmv_q     <= rmv_d;
    wr_q      <= wr_d;
    req_q     <= req_d;
    rsp_q     <= rsp_d;
  end
endmodule

// ===== hdl/dlsq_ram.sv =====
// Generic single port RAM with registered read.
module dlsq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end
endmodule

// ===== hdl/dlsq_checker.sv =====
// Port checker for the sleep queue, bound to the top level.
module dlsq_checker
  import dlsq_pkg::*;
(
  input logic clk_i,
  input logic rst_ni,
  input logic req_valid_i,
  input logic req_ready_o,
  input logic rsp_valid_o,
  input logic rsp_ready_i,
  input rsp_t rsp_o
);
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && !rsp_ready_i |=> rsp_valid_o && $stable(rsp_o))
    else $error("response changed while stalled");

  a_busy_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_o |=> !req_ready_o)
    else $error("request taken while busy");

  a_no_cancel_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.removed_count != 5'd0 |-> rsp_o.thread_out == 8'd0)
    else $error("cancel result carries a thread");

  a_status_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o && rsp_o.status != StOk |-> rsp_o.last)
    else $error("error status on a non final result");
endmodule

bind delta_list_sleep_queue_unit dlsq_checker u_dlsq_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .req_valid_i(req_valid_i),
  .req_ready_o(req_ready_o),
  .rsp_valid_o(rsp_valid_o),
  .rsp_ready_i(rsp_ready_i),
  .rsp_o      (rsp_o)
);
